FILE: design/dqms_pkg.sv
// Shared types and constants for the dual queue minimum selector.
`timescale 1ns / 1ps

package dqms_pkg;

  // Fixed field widths of the request and result words
  localparam int NODE_W   = 16;
  localparam int WEIGHT_W = 32;
  localparam int CAP_W    = 9;
  localparam int IDX_W    = 1;

  // Capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_FIRST_CAP  = 1'b0;
  localparam logic [IDX_W-1:0] REG_SECOND_CAP = 1'b1;

  // Queue identifiers
  localparam logic QUEUE_FIRST  = 1'b0;
  localparam logic QUEUE_SECOND = 1'b1;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_MIN  = 2'd3
  } req_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the request word
    logic commit;  // update the queues and load the result word
  } ctl_cmd_t;

endpackage

FILE: design/dqms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dqms_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/dqms_ctrl.sv
// Controller: sequences request capture, queue update and result handshake.
`timescale 1ns / 1ps

module dqms_ctrl
  import dqms_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ctl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // Capture on an accepted word, update once the result register is free
  always_comb begin
    cmd.load   = in_valid && !in_stall;
    cmd.commit = (state == S_EXEC) && (!out_valid || !out_stall);
  end

  // Hold state and handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result word once taken, unless a new one replaces it
      if (out_valid && !out_stall && !cmd.commit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state    <= S_EXEC;
            in_stall <= 1'b1;
          end
        end
        S_EXEC: begin
          if (cmd.commit) begin
            state     <= S_IDLE;
            in_stall  <= 1'b0;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: design/dqms_datapath.sv
// Datapath: queue pointers, entry RAMs, front selection and result register.
`timescale 1ns / 1ps

module dqms_datapath
  import dqms_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256,
  parameter int REF_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ctl_cmd_t            cmd,
  input  logic                cfg_wr_en,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CAP_W-1:0]    cfg_data,
  input  logic [1:0]          req_type,
  input  logic                queue_select,
  input  logic [NODE_W-1:0]   node_ref,
  input  logic [WEIGHT_W-1:0] weight,
  output logic                hit,
  output logic [NODE_W-1:0]   out_node_ref,
  output logic [WEIGHT_W-1:0] out_weight,
  output logic                source_queue,
  output logic                dropped,
  output logic                first_empty,
  output logic                first_single,
  output logic                first_full,
  output logic                second_empty,
  output logic                second_single,
  output logic                second_full
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int KEEP_W  = (REF_BITS < NODE_W) ? REF_BITS : NODE_W;
  localparam int ENTRY_W = KEEP_W + WEIGHT_W;
  localparam int CW      = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;

  // Captured request
  req_t                req;
  logic                sel;
  logic [KEEP_W-1:0]   in_ref;
  logic [WEIGHT_W-1:0] in_weight;

  // Queue state
  logic [CAP_W-1:0] cap  [2];
  logic [PTR_W-1:0] head [2];
  logic [PTR_W-1:0] tail [2];
  logic             occ  [2];

  logic [PTR_W-1:0] head_next [2];
  logic [PTR_W-1:0] tail_next [2];
  logic             occ_next  [2];

  // RAM ports
  logic               wr_en   [2];
  logic [PTR_W-1:0]   wr_addr [2];
  logic [ENTRY_W-1:0] rd_data [2];
  logic [ENTRY_W-1:0] wr_data;

  // Decision signals
  logic [CW-1:0]       lim       [2];
  logic                full_now  [2];
  logic                full_next [2];
  logic                single_next [2];
  logic                pick;
  logic                push;
  logic                pop;
  logic                take;
  logic                drop;
  logic [ENTRY_W-1:0]  picked;

  assign wr_data = {in_ref, in_weight};

  // Entry RAMs, read at the current head every cycle
  for (genvar g = 0; g < 2; g++) begin : g_queue
    dqms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en[g]),
      .wr_addr (wr_addr[g]),
      .wr_data (wr_data),
      .rd_addr (head[g]),
      .rd_data (rd_data[g])
    );
  end

  // Clamp capacity to 1..QUEUE_DEPTH and find the current full status
  always_comb begin
    for (int q = 0; q < 2; q++) begin
      if (cap[q] == '0) begin
        lim[q] = '0;
      end else if (CW'(cap[q]) > CW'(QUEUE_DEPTH)) begin
        lim[q] = CW'(QUEUE_DEPTH - 1);
      end else begin
        lim[q] = CW'(cap[q]) - CW'(1);
      end
      full_now[q] = occ[q] && (CW'(tail[q]) >= lim[q]);
    end
  end

  // Choose the queue; on a tie or an empty first queue take the second
  always_comb begin
    if (req == REQ_MIN) begin
      if (!occ[0]) begin
        pick = QUEUE_SECOND;
      end else if (!occ[1]) begin
        pick = QUEUE_FIRST;
      end else if (rd_data[0][WEIGHT_W-1:0] < rd_data[1][WEIGHT_W-1:0]) begin
        pick = QUEUE_FIRST;
      end else begin
        pick = QUEUE_SECOND;
      end
    end else begin
      pick = sel;
    end
    picked = (pick == QUEUE_SECOND) ? rd_data[1] : rd_data[0];
    take   = (req != REQ_ENQ) && ((pick == QUEUE_SECOND) ? occ[1] : occ[0]);
    pop    = take && ((req == REQ_DEQ) || (req == REQ_MIN));
    drop   = (req == REQ_ENQ) && ((sel == QUEUE_SECOND) ? full_now[1] : full_now[0]);
    push   = (req == REQ_ENQ) && !drop;
  end

  // Advance pointers for the push or pop, and derive status after the step
  always_comb begin
    for (int q = 0; q < 2; q++) begin
      head_next[q] = head[q];
      tail_next[q] = tail[q];
      occ_next[q]  = occ[q];
      wr_en[q]     = 1'b0;
      wr_addr[q]   = occ[q] ? tail[q] + PTR_W'(1) : '0;
      if (push && (sel == 1'(q))) begin
        wr_en[q] = cmd.commit;
        if (occ[q]) begin
          tail_next[q] = tail[q] + PTR_W'(1);
        end else begin
          head_next[q] = '0;
          tail_next[q] = '0;
          occ_next[q]  = 1'b1;
        end
      end
      if (pop && (pick == 1'(q))) begin
        if (head[q] >= tail[q]) begin
          head_next[q] = '0;
          tail_next[q] = '0;
          occ_next[q]  = 1'b0;
        end else begin
          head_next[q] = head[q] + PTR_W'(1);
        end
      end
      full_next[q]   = occ_next[q] && (CW'(tail_next[q]) >= lim[q]);
      single_next[q] = occ_next[q] && (head_next[q] == tail_next[q]);
    end
  end

  // Hold capacity registers and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < 2; q++) begin
        cap[q]  <= CAP_RESET;
        head[q] <= '0;
        tail[q] <= '0;
        occ[q]  <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_FIRST_CAP) begin
          cap[0] <= cfg_data;
        end else begin
          cap[1] <= cfg_data;
        end
      end
      if (cmd.commit) begin
        for (int q = 0; q < 2; q++) begin
          head[q] <= head_next[q];
          tail[q] <= tail_next[q];
          occ[q]  <= occ_next[q];
        end
      end
    end
  end

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req       <= req_t'(req_type);
      sel       <= queue_select;
      in_ref    <= node_ref[KEEP_W-1:0];
      in_weight <= weight;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit           <= take;
      out_node_ref  <= take ? NODE_W'(picked[ENTRY_W-1:WEIGHT_W]) : '0;
      out_weight    <= take ? picked[WEIGHT_W-1:0] : '0;
      source_queue  <= take ? pick : QUEUE_FIRST;
      dropped       <= drop;
      first_empty   <= !occ_next[0];
      first_single  <= single_next[0];
      first_full    <= full_next[0];
      second_empty  <= !occ_next[1];
      second_single <= single_next[1];
      second_full   <= full_next[1];
    end
  end

endmodule

FILE: design/dual_queue_min_selector.sv
// Top level of the dual queue minimum selector.
//
// Two linear queues of (node reference, weight) entries, each in its own RAM.
// A request word enqueues, dequeues or peeks at one queue, or dequeues the
// front with the smaller weight (ties and an empty first queue go to the
// second queue). A request is captured while idle; in the execute state the
// registered RAM read of both head entries feeds the head and tail update and
// the result word. A result word waiting on out_stall holds the update of the
// next request, not its acceptance. The user must write capacities through the
// cfg port only while the block is idle, which the block does not enforce; 0
// acts as 1, above QUEUE_DEPTH as QUEUE_DEPTH. No clearing pass after reset.
`timescale 1ns / 1ps

module dual_queue_min_selector
  import dqms_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256,
  parameter int REF_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CAP_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic                queue_select,
  input  logic [NODE_W-1:0]   node_ref,
  input  logic [WEIGHT_W-1:0] weight,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                hit,
  output logic [NODE_W-1:0]   out_node_ref,
  output logic [WEIGHT_W-1:0] out_weight,
  output logic                source_queue,
  output logic                dropped,
  output logic                first_empty,
  output logic                first_single,
  output logic                first_full,
  output logic                second_empty,
  output logic                second_single,
  output logic                second_full
);

  ctl_cmd_t cmd;

  // Sequence each word
  dqms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Queues and result
  dqms_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .REF_BITS    (REF_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .queue_select  (queue_select),
    .node_ref      (node_ref),
    .weight        (weight),
    .hit           (hit),
    .out_node_ref  (out_node_ref),
    .out_weight    (out_weight),
    .source_queue  (source_queue),
    .dropped       (dropped),
    .first_empty   (first_empty),
    .first_single  (first_single),
    .first_full    (first_full),
    .second_empty  (second_empty),
    .second_single (second_single),
    .second_full   (second_full)
  );

endmodule
